[rtl/vectored_interrupt_controller_macros.svh]
// assertion macros for the vectored interrupt controller
// expects signals clk and arst_n in the scope of use
`ifndef VECTORED_INTERRUPT_CONTROLLER_MACROS_SVH
`define VECTORED_INTERRUPT_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

// checked at every rising clock edge, muted while reset is active
`define VIC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every rising clock edge, including during reset
`define VIC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VIC_ASSERT(label, prop, msg)
`define VIC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[rtl/vic_pkg.sv]
// shared types, event codes and vector helper for the interrupt controller
// no dependencies
package vic_pkg;

	localparam int unsigned NUM_SOURCES = 5;
	localparam logic [6:0] VECTOR_BASE = 7'h40;

	// event codes, code seven is unused and ignored
	typedef enum logic [2:0] {
		FUNC_TICK    = 3'd0,
		FUNC_RAISE   = 3'd1,
		FUNC_WR_EN   = 3'd2,
		FUNC_WR_FLAG = 3'd3,
		FUNC_ENABLE  = 3'd4,
		FUNC_DISABLE = 3'd5,
		FUNC_HALT    = 3'd6
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] pc_now;
		logic [2:0]  source;
		logic [7:0]  reg_value;
	} req_t;

	typedef struct packed {
		logic        taken;
		logic [6:0]  vector;
		logic [15:0] return_pc;
		logic [7:0]  enable_out;
		logic [7:0]  flags_out;
		logic        halted_out;
		logic        master_out;
	} rsp_t;

	typedef struct packed {
		logic [7:0] enable_mask;
		logic [7:0] pending_flags;
		logic       master_enable;
		logic       enable_pending;
		logic       halted;
	} state_t;

	// jump address of a source: base plus eight per source
	function automatic logic [6:0] vector_of(input logic [2:0] idx);
		return VECTOR_BASE + {1'b0, idx, 3'b000};
	endfunction

endpackage

[rtl/vic_eval.sv]
// next-state and result logic for one controller event
// depends on vic_pkg
module vic_eval import vic_pkg::*; (
	input  state_t st,
	input  req_t   req,
	output state_t st_next,
	output rsp_t   rsp
);

	logic [NUM_SOURCES-1:0] ready_src;
	logic                   found;
	logic [2:0]             idx;

	// lowest-numbered source that is pending and enabled
	always_comb begin
		ready_src = st.pending_flags[NUM_SOURCES-1:0] & st.enable_mask[NUM_SOURCES-1:0];
		found = |ready_src;
		idx = '0;
		for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
			if (ready_src[i]) begin
				idx = 3'(i);
			end
		end
	end

	// event decode and state update
	always_comb begin
		st_next = st;
		rsp = '0;
		unique case (req.func)
			FUNC_TICK: begin
				if (st.halted && (st.pending_flags != 8'd0)) begin
					st_next.halted = 1'b0;
				end
				if (st.master_enable) begin
					if (found) begin
						rsp.taken = 1'b1;
						rsp.vector = vector_of(idx);
						rsp.return_pc = req.pc_now;
						st_next.pending_flags = st.pending_flags & ~(8'd1 << idx);
						st_next.halted = 1'b0;
						st_next.master_enable = 1'b0;
					end
					st_next.enable_pending = 1'b0;
				end
				if (st_next.enable_pending) begin
					st_next.master_enable = 1'b1;
				end
			end
			FUNC_RAISE: begin
				if (req.source < 3'(NUM_SOURCES)) begin
					st_next.pending_flags = st.pending_flags | (8'd1 << req.source);
				end
			end
			FUNC_WR_EN: begin
				st_next.enable_mask = req.reg_value;
			end
			FUNC_WR_FLAG: begin
				st_next.pending_flags = req.reg_value;
			end
			FUNC_ENABLE: begin
				st_next.enable_pending = 1'b1;
			end
			FUNC_DISABLE: begin
				st_next.master_enable = 1'b0;
			end
			FUNC_HALT: begin
				st_next.halted = 1'b1;
			end
			default: begin
			end
		endcase
		rsp.enable_out = st_next.enable_mask;
		rsp.flags_out = st_next.pending_flags;
		rsp.halted_out = st_next.halted;
		rsp.master_out = st_next.master_enable;
	end

endmodule

[rtl/vectored_interrupt_controller.sv]
// vectored interrupt controller, five sources, one event per transaction
// pipeline: the request is held in an input register, the response in an output register
// throughput: one transaction per cycle unless rsp_ready stalls; event logic is combinational
// reset: all controller state and both pipeline valids clear asynchronously
// depends on vic_pkg, vic_eval and the assertion macro header
`include "vectored_interrupt_controller_macros.svh"

module vectored_interrupt_controller import vic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	req_t   req_s1;
	logic   valid_s1;
	state_t state_q;
	state_t state_next;
	rsp_t   rsp_q;
	rsp_t   rsp_d;
	logic   rsp_valid_q;
	logic   advance;
	logic   rsp_taken;
	logic   vector_in_slot;
	logic   rsp_in_step;

	// the registered event moves on when the output slot is free or being drained
	assign advance = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	vic_eval u_eval (
		.st      (state_q),
		.req     (req_s1),
		.st_next (state_next),
		.rsp     (rsp_d)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// controller state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// terms used by the checks below
	assign rsp_taken = rsp_valid_q && rsp_q.taken;
	assign vector_in_slot = (rsp_q.vector[2:0] == 3'd0) && (rsp_q.vector >= VECTOR_BASE) &&
		(rsp_q.vector <= 7'h60);
	assign rsp_in_step = (state_q.enable_mask == rsp_q.enable_out) &&
		(state_q.pending_flags == rsp_q.flags_out) &&
		(state_q.halted == rsp_q.halted_out) &&
		(state_q.master_enable == rsp_q.master_out);

	// a dispatch always leaves the cpu running with the master bit off
	`VIC_ASSERT(a_taken_clears, rsp_taken |-> !(rsp_q.halted_out || rsp_q.master_out), "halt set")

	// a dispatch vector is one of the five slots
	`VIC_ASSERT(a_vector_slot, rsp_taken |-> vector_in_slot, "vector outside slot table")

	// no dispatch means zero vector and return address
	`VIC_ASSERT(a_idle_zero, (rsp_valid_q && !rsp_q.taken) |-> (rsp_q.vector == 7'd0), "vector")
	`VIC_ASSERT(a_idle_pc, (rsp_valid_q && !rsp_q.taken) |-> (rsp_q.return_pc == 16'd0), "pc")

	// the held response mirrors the live controller state
	`VIC_ASSERT(a_state_mirror, rsp_valid_q |-> rsp_in_step, "response out of step with state")

endmodule
